// ----- rtl/core/wildcard_glob_matcher_assert.svh -----
// Assertion macros shared by the wildcard glob matcher RTL.
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define WGM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define WGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/wgm_pkg.sv -----
// Types, constants and the microcode table of the wildcard glob matcher.
package wgm_pkg;

  // Buffer sizes and the widths that follow from them.
  localparam int PAT_DEPTH = 64;
  localparam int SUB_DEPTH = 256;
  localparam int PAT_AW    = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
  localparam int SUB_AW    = (SUB_DEPTH > 1) ? $clog2(SUB_DEPTH) : 1;
  localparam int PAT_CW    = $clog2(PAT_DEPTH + 1);
  localparam int SUB_CW    = $clog2(SUB_DEPTH + 1);
  localparam logic [PAT_CW-1:0] PAT_FULL = PAT_CW'(PAT_DEPTH);
  localparam logic [SUB_CW-1:0] SUB_FULL = SUB_CW'(SUB_DEPTH);

  // Character codes with a special meaning in the pattern.
  localparam logic [15:0] CH_STAR = 16'h002A;
  localparam logic [15:0] CH_ANY  = 16'h003F;

  // Transaction opcodes.
  localparam logic [1:0] OP_PAT  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_EVAL = 2'd2;

  // Payload of the input and result channels.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] char_code;
  } in_t;

  typedef struct packed {
    logic matched;
    logic overflowed;
  } out_t;

  // Microprogram step addresses.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] S_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] S_CHECK  = 3'd1;
  localparam logic [STEP_W-1:0] S_FETCH  = 3'd2;
  localparam logic [STEP_W-1:0] S_EVAL   = 3'd3;
  localparam logic [STEP_W-1:0] S_TFETCH = 3'd4;
  localparam logic [STEP_W-1:0] S_TEVAL  = 3'd5;
  localparam logic [STEP_W-1:0] S_EMIT   = 3'd6;

  // Datapath operations.
  localparam logic [1:0] DP_LOAD = 2'd0;
  localparam logic [1:0] DP_EVAL = 2'd1;
  localparam logic [1:0] DP_TAIL = 2'd2;
  localparam logic [1:0] DP_EMIT = 2'd3;

  // Branch conditions.
  localparam logic [2:0] C_NONE     = 3'd0;
  localparam logic [2:0] C_EVAL_ACC = 3'd1;
  localparam logic [2:0] C_OVF      = 3'd2;
  localparam logic [2:0] C_SUB_DONE = 3'd3;
  localparam logic [2:0] C_FINISH   = 3'd4;
  localparam logic [2:0] C_OUT_FREE = 3'd5;

  // One microcode word.
  typedef struct packed {
    logic              in_rdy;
    logic              rd_en;
    logic [1:0]        dp_op;
    logic [2:0]        cond;
    logic [STEP_W-1:0] jmp;
    logic [STEP_W-1:0] nxt;
  } ctl_t;

  // Status flags the datapath hands back to the sequencer.
  typedef struct packed {
    logic eval_acc;
    logic ovf;
    logic sub_done;
    logic finish;
    logic out_free;
  } sts_t;

  // Microcode ROM: taken branch goes to jmp, otherwise to nxt.
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '{in_rdy: 1'b0, rd_en: 1'b0, dp_op: DP_LOAD, cond: C_NONE,
          jmp: S_IDLE, nxt: S_IDLE};
    unique case (step)
      S_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = C_EVAL_ACC;
        w.jmp    = S_CHECK;
        w.nxt    = S_IDLE;
      end
      S_CHECK: begin
        w.cond = C_OVF;
        w.jmp  = S_EMIT;
        w.nxt  = S_FETCH;
      end
      S_FETCH: begin
        w.rd_en = 1'b1;
        w.cond  = C_SUB_DONE;
        w.jmp   = S_TEVAL;
        w.nxt   = S_EVAL;
      end
      S_EVAL: begin
        w.dp_op = DP_EVAL;
        w.cond  = C_FINISH;
        w.jmp   = S_EMIT;
        w.nxt   = S_FETCH;
      end
      S_TFETCH: begin
        w.rd_en = 1'b1;
        w.nxt   = S_TEVAL;
      end
      S_TEVAL: begin
        w.dp_op = DP_TAIL;
        w.cond  = C_FINISH;
        w.jmp   = S_EMIT;
        w.nxt   = S_TFETCH;
      end
      S_EMIT: begin
        w.dp_op = DP_EMIT;
        w.cond  = C_OUT_FREE;
        w.jmp   = S_IDLE;
        w.nxt   = S_EMIT;
      end
      default: begin
        w.nxt = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/wgm_ram.sv -----
// Generic simple dual-port RAM with a registered read.
module wgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/wgm_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional jumps.
module wgm_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  wgm_pkg::sts_t sts,
  output wgm_pkg::ctl_t ctl
);

  logic [wgm_pkg::STEP_W-1:0] step_r;
  logic [wgm_pkg::STEP_W-1:0] step_nxt;
  logic                       take;

  // Control word of the current step.
  assign ctl = wgm_pkg::ucode(step_r);

  // Pick the branch condition named by the control word.
  always_comb begin
    unique case (ctl.cond)
      wgm_pkg::C_NONE:     take = 1'b0;
      wgm_pkg::C_EVAL_ACC: take = sts.eval_acc;
      wgm_pkg::C_OVF:      take = sts.ovf;
      wgm_pkg::C_SUB_DONE: take = sts.sub_done;
      wgm_pkg::C_FINISH:   take = sts.finish;
      wgm_pkg::C_OUT_FREE: take = sts.out_free;
      default:             take = 1'b0;
    endcase
    step_nxt = take ? ctl.jmp : ctl.nxt;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= wgm_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- rtl/core/wgm_dp.sv -----
// Matcher datapath: buffers, counts, scan pointers and the result register.
`include "wildcard_glob_matcher_assert.svh"

module wgm_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  wgm_pkg::ctl_t ctl,
  input  logic          in_valid,
  input  wgm_pkg::in_t  in_data,
  output wgm_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output wgm_pkg::out_t out_data
);

  localparam int PCW = wgm_pkg::PAT_CW;
  localparam int SCW = wgm_pkg::SUB_CW;
  localparam int PAW = wgm_pkg::PAT_AW;
  localparam int SAW = wgm_pkg::SUB_AW;

  logic [PCW-1:0] pcnt_r, pcnt_nxt;
  logic [SCW-1:0] scnt_r, scnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic [PCW-1:0] pp_r, pp_nxt;
  logic [SCW-1:0] sp_r, sp_nxt;
  logic [PAW-1:0] star_p_r, star_p_nxt;
  logic [SCW-1:0] star_s_r, star_s_nxt;
  logic           have_star_r, have_star_nxt;
  logic           match_r, match_nxt;
  logic           out_valid_r, out_valid_nxt;
  wgm_pkg::out_t  out_r, out_nxt;

  logic        in_fire;
  logic        pat_we;
  logic        sub_we;
  logic [15:0] pat_q;
  logic [15:0] sub_q;
  logic        p_ok;
  logic        is_star;
  logic        hit;
  logic        finish;
  logic        out_free;
  logic        emit_fire;

  // Character buffers.
  wgm_ram #(.WIDTH(16), .DEPTH(wgm_pkg::PAT_DEPTH)) u_pat_ram (
    .clk     (clk),
    .we      (pat_we),
    .wr_addr (pcnt_r[PAW-1:0]),
    .wr_data (in_data.char_code),
    .rd_en   (ctl.rd_en),
    .rd_addr (pp_r[PAW-1:0]),
    .rd_data (pat_q)
  );

  wgm_ram #(.WIDTH(16), .DEPTH(wgm_pkg::SUB_DEPTH)) u_sub_ram (
    .clk     (clk),
    .we      (sub_we),
    .wr_addr (scnt_r[SAW-1:0]),
    .wr_data (in_data.char_code),
    .rd_en   (ctl.rd_en),
    .rd_addr (sp_r[SAW-1:0]),
    .rd_data (sub_q)
  );

  // Transaction accept and buffer appends.
  assign in_fire = in_valid && ctl.in_rdy;
  assign pat_we  = in_fire && (in_data.opcode == wgm_pkg::OP_PAT) &&
                   (pcnt_r != wgm_pkg::PAT_FULL);
  assign sub_we  = in_fire && (in_data.opcode == wgm_pkg::OP_SUB) &&
                   (scnt_r != wgm_pkg::SUB_FULL);

  // Character compare on the data read in the previous step.
  assign p_ok    = pp_r < pcnt_r;
  assign is_star = p_ok && (pat_q == wgm_pkg::CH_STAR);
  assign hit     = p_ok && ((pat_q == wgm_pkg::CH_ANY) || (pat_q == sub_q));

  // The result slot is free when empty or drained this cycle.
  assign out_free  = !out_valid_r || out_ready;
  assign emit_fire = (ctl.dp_op == wgm_pkg::DP_EMIT) && out_free;

  // Next-state logic for every datapath operation.
  always_comb begin
    pcnt_nxt      = pcnt_r;
    scnt_nxt      = scnt_r;
    ovf_nxt       = ovf_r;
    pp_nxt        = pp_r;
    sp_nxt        = sp_r;
    star_p_nxt    = star_p_r;
    star_s_nxt    = star_s_r;
    have_star_nxt = have_star_r;
    match_nxt     = match_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    finish        = 1'b0;

    unique case (ctl.dp_op)
      wgm_pkg::DP_LOAD: begin
        if (in_fire) begin
          unique case (in_data.opcode)
            wgm_pkg::OP_PAT: begin
              if (pat_we) begin
                pcnt_nxt = pcnt_r + PCW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            wgm_pkg::OP_SUB: begin
              if (sub_we) begin
                scnt_nxt = scnt_r + SCW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            wgm_pkg::OP_EVAL: begin
              pp_nxt        = '0;
              sp_nxt        = '0;
              have_star_nxt = 1'b0;
              match_nxt     = 1'b0;
            end
            default: begin
              // The unused opcode changes nothing.
            end
          endcase
        end
      end
      wgm_pkg::DP_EVAL: begin
        priority if (is_star) begin
          if ((pp_r + PCW'(1)) == pcnt_r) begin
            // A trailing star accepts the rest of the subject.
            match_nxt = 1'b1;
            finish    = 1'b1;
          end else begin
            have_star_nxt = 1'b1;
            star_p_nxt    = pp_r[PAW-1:0];
            star_s_nxt    = sp_r;
            pp_nxt        = pp_r + PCW'(1);
          end
        end else if (hit) begin
          pp_nxt = pp_r + PCW'(1);
          sp_nxt = sp_r + SCW'(1);
        end else if (have_star_r) begin
          // Backtrack: let the last star swallow one more character.
          pp_nxt     = PCW'(star_p_r) + PCW'(1);
          star_s_nxt = star_s_r + SCW'(1);
          sp_nxt     = star_s_r + SCW'(1);
        end else begin
          match_nxt = 1'b0;
          finish    = 1'b1;
        end
      end
      wgm_pkg::DP_TAIL: begin
        // Subject is used up: only stars may remain in the pattern.
        if (is_star) begin
          pp_nxt = pp_r + PCW'(1);
        end else begin
          match_nxt = (pp_r == pcnt_r);
          finish    = 1'b1;
        end
      end
      wgm_pkg::DP_EMIT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.matched    = match_r && !ovf_r;
          out_nxt.overflowed = ovf_r;
          pcnt_nxt           = '0;
          scnt_nxt           = '0;
          ovf_nxt            = 1'b0;
        end
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r      <= '0;
      scnt_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pcnt_r      <= pcnt_nxt;
      scnt_r      <= scnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan pointers and result payload.
  always_ff @(posedge clk) begin
    pp_r        <= pp_nxt;
    sp_r        <= sp_nxt;
    star_p_r    <= star_p_nxt;
    star_s_r    <= star_s_nxt;
    have_star_r <= have_star_nxt;
    match_r     <= match_nxt;
    out_r       <= out_nxt;
  end

  // Status back to the sequencer and the result channel.
  assign sts.eval_acc = in_fire && (in_data.opcode == wgm_pkg::OP_EVAL);
  assign sts.ovf      = ovf_r;
  assign sts.sub_done = sp_r >= scnt_r;
  assign sts.finish   = finish;
  assign sts.out_free = out_free;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  // An overflowed result never reports a match.
  `WGM_ASSERT_NOW(a_ovf_no_match, out_valid_r && out_r.overflowed, !out_r.matched,
    "overflowed result reports a match")
  // A delivered result leaves empty buffers and a clear overflow flag.
  `WGM_ASSERT_NEXT(a_emit_clears, emit_fire,
    (pcnt_r == '0) && (scnt_r == '0) && !ovf_r, "buffers not cleared after result")
  // Scan pointers stay within the loaded lengths while matching.
  `WGM_ASSERT_NOW(a_ptr_range, ctl.dp_op == wgm_pkg::DP_EVAL,
    (pp_r <= pcnt_r) && (sp_r < scnt_r), "scan pointer beyond buffer length")
  // The backtrack point never lies ahead of the subject pointer.
  `WGM_ASSERT_NOW(a_star_behind, (ctl.dp_op == wgm_pkg::DP_EVAL) && have_star_r,
    star_s_r <= sp_r, "backtrack point ahead of subject pointer")

endmodule

// ----- rtl/core/wildcard_glob_matcher.sv -----
// Top level of the wildcard glob matcher.
//
// Usage: characters arrive on the input channel (in_valid, in_ready, in_data).
// Opcode OP_PAT appends in_data.char_code to the pattern buffer, OP_SUB to
// the subject buffer, and OP_EVAL matches the whole subject against the whole
// pattern ('*' any run, '?' one character), then clears both buffers. Only
// OP_EVAL yields a result on out_valid, out_ready, out_data.
// Appends are taken one per cycle while the matcher is idle. An evaluate runs
// a check step, then scan steps of the shared compare unit (each a buffer
// read, then a compare), then a step to post the result. An evaluate after
// a dropped append goes from its check step straight to the result step.
// The 64-entry pattern RAM and 256-entry subject RAM have one read port each,
// which is why a scan step reads before it compares. No new transaction is
// taken while a match runs.
// Reset clears the counts, the overflow flag and the result slot; buffer
// contents need no clearing. A stalled receiver holds the result; appends are
// still taken, and a further evaluate waits in its result step.
module wildcard_glob_matcher (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wgm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wgm_pkg::out_t out_data
);

  wgm_pkg::ctl_t ctl;
  wgm_pkg::sts_t sts;

  // Microcode sequencer.
  wgm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Datapath with buffers and result register.
  wgm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = ctl.in_rdy;

endmodule
